[sv/dte_pkg.sv]
// ----------------------------------------------------------------------------
// dte_pkg
// Shared constants for the digram table expander: table, stack and run sizes.
// ----------------------------------------------------------------------------
package dte_pkg;

  localparam int TABLE_SIZE  = 256;
  localparam int STACK_DEPTH = 256;
  localparam int MAX_RUN     = 64;

  localparam int BYTE_W = 8;
  localparam int TAW    = $clog2(TABLE_SIZE);
  localparam int SAW    = $clog2(STACK_DEPTH);
  localparam int SPW    = $clog2(STACK_DEPTH + 1);
  localparam int OAW    = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;
  localparam int CW     = $clog2(MAX_RUN + 1);

  localparam logic MODE_WRITE  = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

endpackage

[sv/digram_table_expander_core.sv]
// ----------------------------------------------------------------------------
// digram_table_expander_core
// Recursive byte pair decoder with a loadable pair table and a pending stack.
// ----------------------------------------------------------------------------
// A table-write request (mode 0) writes one table entry and leaves the block
// idle. A decode request (mode 1) walks the pair table depth-first through
// one shared table read port: every table lookup takes an EVAL state, and
// every pop from the pending stack takes a further POP state. The expanded
// bytes are collected in an output buffer and then handed out, each byte
// through an OLOAD and an OWAIT state that holds while the receiver stalls,
// the last one flagged with run_last; collecting first lets every byte carry
// the fault state as it stands after the whole expansion. The block takes no
// new request until the last byte of a run has been taken. After reset every
// table entry reads as a literal, so no clearing pass is needed.
module digram_table_expander_core
  import dte_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              mode,
  input  logic [BYTE_W-1:0] entry_index,
  input  logic [BYTE_W-1:0] left_byte,
  input  logic [BYTE_W-1:0] right_byte,
  input  logic [BYTE_W-1:0] code_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [BYTE_W-1:0] out_byte,
  output logic              run_last,
  output logic              fault
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EVAL  = 3'd1;
  localparam logic [2:0] S_POP   = 3'd2;
  localparam logic [2:0] S_ORD   = 3'd3;
  localparam logic [2:0] S_OLOAD = 3'd4;
  localparam logic [2:0] S_OWAIT = 3'd5;

  logic [2:0]              state;
  logic [BYTE_W-1:0]       code;
  logic [SPW-1:0]          sp;
  logic [CW-1:0]           cnt;
  logic [OAW-1:0]          rd_idx;
  logic                    tvalid_q;
  logic [TABLE_SIZE-1:0]   tab_valid;
  logic                    fault_flag;

  logic                    in_take;
  logic                    t_we;
  logic [TAW-1:0]          t_raddr;
  logic [2*BYTE_W-1:0]     t_rdata;
  logic [BYTE_W-1:0]       left_b;
  logic [BYTE_W-1:0]       right_b;
  logic                    is_lit;
  logic                    cap_hit;
  logic                    stack_full;
  logic                    hit_fault;
  logic [SPW-1:0]          sp_m1;
  logic                    s_we;
  logic [BYTE_W-1:0]       s_rdata;
  logic                    o_we;
  logic [OAW-1:0]          o_waddr;
  logic [BYTE_W-1:0]       o_wdata;
  logic [OAW-1:0]          o_raddr;
  logic [BYTE_W-1:0]       o_rdata;

  assign in_stall = (state != S_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign t_we     = in_take && (mode == MODE_WRITE);
  assign fault    = fault_flag;

  // An entry never written since reset reads as a literal of its own index.
  assign left_b  = tvalid_q ? t_rdata[2*BYTE_W-1:BYTE_W] : code;
  assign right_b = tvalid_q ? t_rdata[BYTE_W-1:0] : '0;

  assign is_lit     = (left_b == code);
  assign cap_hit    = (cnt == CW'(MAX_RUN));
  assign stack_full = (sp >= SPW'(STACK_DEPTH));
  assign hit_fault  = (state == S_EVAL) && (is_lit ? cap_hit : stack_full);
  assign sp_m1      = sp - SPW'(1);

  always_comb begin
    unique case (state)
      S_EVAL:  t_raddr = TAW'(left_b);
      S_POP:   t_raddr = TAW'(s_rdata);
      default: t_raddr = TAW'(code_byte);
    endcase
  end

  assign s_we = (state == S_EVAL) && !is_lit && !stack_full;

  always_comb begin
    o_we    = 1'b0;
    o_waddr = cnt[OAW-1:0];
    o_wdata = code;
    if (state == S_EVAL) begin
      if (hit_fault) begin
        // A fault before any byte still yields one zero byte.
        o_we    = (cnt == '0);
        o_waddr = '0;
        o_wdata = '0;
      end else if (is_lit) begin
        o_we = 1'b1;
      end
    end
  end

  assign o_raddr = (state == S_OWAIT) ? OAW'(rd_idx + OAW'(1)) : rd_idx;

  dte_ram #(.WIDTH(2*BYTE_W), .DEPTH(TABLE_SIZE)) u_table (
    .clk   (clk),
    .we    (t_we),
    .waddr (TAW'(entry_index)),
    .wdata ({left_byte, right_byte}),
    .raddr (t_raddr),
    .rdata (t_rdata)
  );

  dte_ram #(.WIDTH(BYTE_W), .DEPTH(STACK_DEPTH)) u_stack (
    .clk   (clk),
    .we    (s_we),
    .waddr (sp[SAW-1:0]),
    .wdata (right_b),
    .raddr (sp_m1[SAW-1:0]),
    .rdata (s_rdata)
  );

  dte_ram #(.WIDTH(BYTE_W), .DEPTH(MAX_RUN)) u_obuf (
    .clk   (clk),
    .we    (o_we),
    .waddr (o_waddr),
    .wdata (o_wdata),
    .raddr (o_raddr),
    .rdata (o_rdata)
  );

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      sp         <= '0;
      cnt        <= '0;
      fault_flag <= 1'b0;
      tab_valid  <= '0;
      out_valid  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (t_we) begin
            tab_valid[TAW'(entry_index)] <= 1'b1;
          end else if (in_take) begin
            sp    <= '0;
            cnt   <= '0;
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (hit_fault) begin
            fault_flag <= 1'b1;
            sp         <= '0;
            if (cnt == '0) begin
              cnt <= CW'(1);
            end
            state <= S_ORD;
          end else if (is_lit) begin
            cnt <= cnt + CW'(1);
            if (sp == '0) begin
              state <= S_ORD;
            end else begin
              sp    <= sp_m1;
              state <= S_POP;
            end
          end else begin
            sp <= sp + SPW'(1);
          end
        end
        S_POP: begin
          state <= S_EVAL;
        end
        S_ORD: begin
          state <= S_OLOAD;
        end
        S_OLOAD: begin
          out_valid <= 1'b1;
          state     <= S_OWAIT;
        end
        S_OWAIT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            state     <= run_last ? S_IDLE : S_OLOAD;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    tvalid_q <= tab_valid[t_raddr];
    if (in_take) begin
      code <= code_byte;
    end else if (state == S_EVAL && !is_lit) begin
      code <= left_b;
    end else if (state == S_POP) begin
      code <= s_rdata;
    end
    if (state == S_EVAL) begin
      rd_idx <= '0;
    end else if (state == S_OWAIT && !out_stall) begin
      rd_idx <= rd_idx + OAW'(1);
    end
    if (state == S_OLOAD) begin
      out_byte <= o_rdata;
      run_last <= ((CW'(rd_idx) + CW'(1)) == cnt);
    end
  end

  a_fault_sticky: assert property (@(posedge clk) disable iff (rst)
    fault_flag |=> fault_flag)
    else $error("fault flag dropped without reset");

  a_stack_bound: assert property (@(posedge clk) disable iff (rst)
    sp <= SPW'(STACK_DEPTH))
    else $error("stack pointer beyond stack depth");

  a_run_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(MAX_RUN))
    else $error("run count beyond run cap");

  a_no_take_while_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("request taken while a result is pending");

  a_last_to_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && run_last) |=> (state == S_IDLE && !out_valid))
    else $error("block did not return to idle after the last byte");

endmodule

[sv/dte_ram.sv]
// ----------------------------------------------------------------------------
// dte_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module dte_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(DEPTH)-1:0]   waddr,
  input  logic [WIDTH-1:0]           wdata,
  input  logic [$clog2(DEPTH)-1:0]   raddr,
  output logic [WIDTH-1:0]           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
